/* hw/rtl/lpd_pkg.sv */
// Shared types and constants for the length-prefixed deframer.
package lpd_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned LenW    = 32;
    localparam int unsigned LenIdxW = 2;
    localparam int unsigned OutDataW = 3 * ByteW;

    // Parser phase, one-hot
    typedef enum logic [2:0] {
        PH_COMMAND = 3'b001,
        PH_LENGTH  = 3'b010,
        PH_BODY    = 3'b100
    } t_phase;

    typedef struct packed {
        logic [ByteW-1:0] main_command;
        logic [ByteW-1:0] sub_command;
        logic [ByteW-1:0] body_byte;
        logic             last_of_message;
        logic             empty_message;
    } t_result;

endpackage

/* hw/rtl/lpd_in_reg.sv */
// Input register stage holding one received byte.
module lpd_in_reg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [lpd_pkg::ByteW-1:0]  s_axis_tdata,
    input  logic                       i_take,
    output logic                       o_valid,
    output logic [lpd_pkg::ByteW-1:0]  o_byte
);
    import lpd_pkg::*;

    logic             r_valid;
    logic [ByteW-1:0] r_byte;
    logic             n_valid;

    assign s_axis_tready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (s_axis_tvalid && s_axis_tready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_byte <= s_axis_tdata;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

/* hw/rtl/lpd_parser.sv */
// Header/body parser with the result register.
module lpd_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [lpd_pkg::ByteW-1:0] i_byte,
    output logic                      o_take,
    output logic                      o_res_valid,
    output lpd_pkg::t_result          o_res,
    input  logic                      i_res_ready
);
    import lpd_pkg::*;

    t_phase               r_phase, n_phase;
    logic                 r_have_main, n_have_main;
    logic [LenIdxW-1:0]   r_len_idx, n_len_idx;
    logic [LenW-1:0]      r_remaining, n_remaining;
    logic [LenW-1:0]      r_length, n_length;
    logic [ByteW-1:0]     r_main, n_main;
    logic [ByteW-1:0]     r_sub, n_sub;
    logic                 r_res_valid, n_res_valid;
    t_result              r_res, n_res;
    logic                 room;
    logic                 fire;
    logic [LenW-1:0]      len_or;

    assign room   = !r_res_valid || i_res_ready;
    assign fire   = i_valid && room;
    assign o_take = room;

    // length bytes arrive least significant first
    always_comb begin
        len_or = r_length;
        case (r_len_idx)
            2'd0:    len_or[7:0]   = i_byte;
            2'd1:    len_or[15:8]  = i_byte;
            2'd2:    len_or[23:16] = i_byte;
            default: len_or[31:24] = i_byte;
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_have_main = r_have_main;
        n_len_idx   = r_len_idx;
        n_remaining = r_remaining;
        n_length    = r_length;
        n_main      = r_main;
        n_sub       = r_sub;
        n_res_valid = r_res_valid && !i_res_ready;
        n_res       = r_res;
        if (fire) begin
            case (r_phase)
                PH_LENGTH: begin
                    n_length  = len_or;
                    n_len_idx = r_len_idx + 1'b1;
                    if (r_len_idx == LenIdxW'(3)) begin
                        if (len_or == '0) begin
                            n_res_valid           = 1'b1;
                            n_res.main_command    = r_main;
                            n_res.sub_command     = r_sub;
                            n_res.body_byte       = '0;
                            n_res.last_of_message = 1'b1;
                            n_res.empty_message   = 1'b1;
                            n_phase               = PH_COMMAND;
                            n_have_main           = 1'b0;
                        end else begin
                            n_phase     = PH_BODY;
                            n_remaining = len_or;
                        end
                    end
                end
                PH_BODY: begin
                    n_res_valid           = 1'b1;
                    n_res.main_command    = r_main;
                    n_res.sub_command     = r_sub;
                    n_res.body_byte       = i_byte;
                    n_res.last_of_message = (r_remaining <= LenW'(1));
                    n_res.empty_message   = 1'b0;
                    if (r_remaining <= LenW'(1)) begin
                        n_phase     = PH_COMMAND;
                        n_have_main = 1'b0;
                    end else begin
                        n_remaining = r_remaining - LenW'(1);
                    end
                end
                default: begin
                    if (!r_have_main) begin
                        n_main      = i_byte;
                        n_have_main = 1'b1;
                    end else begin
                        n_sub       = i_byte;
                        n_phase     = PH_LENGTH;
                        n_len_idx   = '0;
                        n_length    = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_COMMAND;
            r_have_main <= 1'b0;
            r_len_idx   <= '0;
            r_remaining <= '0;
            r_length    <= '0;
            r_main      <= '0;
            r_sub       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_have_main <= n_have_main;
            r_len_idx   <= n_len_idx;
            r_remaining <= n_remaining;
            r_length    <= n_length;
            r_main      <= n_main;
            r_sub       <= n_sub;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

/* hw/rtl/length_prefixed_deframer_unit.sv */
// Length-prefixed deframer: one byte in per cycle, at most one result byte out per input byte.
// Each message is a main command byte, a sub command byte, a 4-byte little-endian
// body length, then the body. Every body byte comes out with both command bytes,
// tlast on the final byte; a zero-length message gives one result with tuser set
// (empty message) and tdata body byte zero. Header bytes give no result. The unit
// takes one byte every clock when the output is drained; each input byte is held in the
// input register, then its result in the result register.
module length_prefixed_deframer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lpd_pkg::ByteW-1:0]     s_axis_tdata,  // [7:0] data_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lpd_pkg::OutDataW-1:0]  m_axis_tdata,  // [7:0] main_command,
                                                         // [15:8] sub_command,
                                                         // [23:16] body_byte
    output logic                          m_axis_tlast,  // last_of_message
    output logic                          m_axis_tuser   // empty_message
);
    import lpd_pkg::*;

    logic             in_valid;
    logic [ByteW-1:0] in_byte;
    logic             take;
    t_result          res;

    lpd_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_take        (take),
        .o_valid       (in_valid),
        .o_byte        (in_byte)
    );

    lpd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_byte      (in_byte),
        .o_take      (take),
        .o_res_valid (m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tdata = {res.body_byte, res.sub_command, res.main_command};
    assign m_axis_tlast = res.last_of_message;
    assign m_axis_tuser = res.empty_message;

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the length-prefixed deframer: header, body and empty-message framing.
`timescale 1ns / 1ps

module tb_top;
    import lpd_pkg::*;

    localparam int unsigned CMD_BYTES   = 2;
    localparam int unsigned LEN_BYTES   = 4;
    localparam int          RANDOM_BYTES = 1350;
    localparam int          TAIL_CYCLES  = 20;
    localparam int          CYCLE_LIMIT  = 4_000_000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [ByteW-1:0]       s_axis_tdata;   // [7:0] data_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OutDataW-1:0]    m_axis_tdata;   // [7:0] main_command, [15:8] sub_command,
                                            // [23:16] body_byte
    logic                   m_axis_tlast;   // last_of_message
    logic                   m_axis_tuser;   // empty_message

    // deframer shadow state
    t_phase                 frame_phase;
    logic [LenW-1:0]        frame_remaining;
    logic [ByteW-1:0]       frame_main;
    logic [ByteW-1:0]       frame_sub;
    logic [LenW-1:0]        frame_length;

    t_result                pending_results[$];
    logic [ByteW-1:0]       body_bytes[$];

    int                     cycle_count = 0;
    int                     mismatch_count = 0;
    int                     results_checked = 0;
    int                     bytes_sent = 0;
    int                     messages_sent = 0;
    int                     empty_sent = 0;
    int                     burst_left = 0;
    int                     rdy_mode = 0;
    int                     rdy_hold = 0;

    length_prefixed_deframer_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("length_prefixed_deframer_unit test failed");
            $finish;
        end
    end

    // Receiver: switches between always-ready, mostly-ready and mostly-stalled spells.
    always @(posedge i_clk) begin
        if (rdy_hold > 0) begin
            rdy_hold <= rdy_hold - 1;
        end else begin
            rdy_mode <= $urandom_range(0, 2);
            rdy_hold <= $urandom_range(50, 400);
        end
        case (rdy_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    task automatic restart_command;
        frame_phase     = PH_COMMAND;
        frame_remaining = CMD_BYTES;
    endtask

    // Advance the shadow deframer by one accepted byte, queueing any result it produces.
    task automatic track_byte(input logic [ByteW-1:0] b);
        t_result             r;
        logic [LenIdxW-1:0]  idx;
        r = '0;
        case (frame_phase)
            PH_LENGTH: begin
                idx = LenIdxW'(LEN_BYTES - frame_remaining);
                frame_length = frame_length | ({24'd0, b} << (8 * idx));
                if (frame_remaining <= 1) begin
                    if (frame_length == 0) begin
                        r.main_command    = frame_main;
                        r.sub_command     = frame_sub;
                        r.last_of_message = 1'b1;
                        r.empty_message   = 1'b1;
                        pending_results.push_back(r);
                        restart_command();
                    end else begin
                        frame_phase     = PH_BODY;
                        frame_remaining = frame_length;
                    end
                end else begin
                    frame_remaining = frame_remaining - 1;
                end
            end
            PH_BODY: begin
                r.main_command    = frame_main;
                r.sub_command     = frame_sub;
                r.body_byte       = b;
                r.last_of_message = (frame_remaining <= 1);
                pending_results.push_back(r);
                if (frame_remaining <= 1) restart_command();
                else frame_remaining = frame_remaining - 1;
            end
            default: begin
                // unknown phase code falls back to the first command byte
                if (frame_phase != PH_COMMAND) restart_command();
                if (frame_remaining >= CMD_BYTES) begin
                    frame_main      = b;
                    frame_remaining = 1;
                end else begin
                    frame_sub       = b;
                    frame_phase     = PH_LENGTH;
                    frame_remaining = LEN_BYTES;
                    frame_length    = '0;
                end
            end
        endcase
    endtask

    // Called right after a rising edge; returns at the edge where the byte is taken.
    task automatic send_byte(input logic [ByteW-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        track_byte(b);
        bytes_sent++;
    endtask

    // Body comes from body_bytes where given, random bytes past its end.
    task automatic send_message(input logic [ByteW-1:0] main_cmd,
                                input logic [ByteW-1:0] sub_cmd,
                                input logic [LenW-1:0]  body_len);
        send_byte(main_cmd);
        send_byte(sub_cmd);
        for (int k = 0; k < LEN_BYTES; k++) send_byte(body_len[8*k +: 8]);
        for (longint k = 0; k < body_len; k++) begin
            if (k < body_bytes.size()) send_byte(body_bytes[k]);
            else send_byte(ByteW'($urandom));
        end
        messages_sent++;
        if (body_len == 0) empty_sent++;
    endtask

    // Hold the sender off until every queued result has been drained.
    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic log_mismatch(input string what, input t_result want, input t_result got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s at cycle %0d: expected main %02h sub %02h body %02h last %0b empty %0b",
                     what, cycle_count,
                     want.main_command, want.sub_command, want.body_byte,
                     want.last_of_message, want.empty_message);
            $display("    got main %02h sub %02h body %02h last %0b empty %0b",
                     got.main_command, got.sub_command, got.body_byte,
                     got.last_of_message, got.empty_message);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            got.main_command    = m_axis_tdata[7:0];
            got.sub_command     = m_axis_tdata[15:8];
            got.body_byte       = m_axis_tdata[23:16];
            got.last_of_message = m_axis_tlast;
            got.empty_message   = m_axis_tuser;
            results_checked++;
            if (pending_results.size() == 0) begin
                log_mismatch("unexpected result", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) log_mismatch("result mismatch", want, got);
            end
        end
    end

    task automatic test_empty_message;
        body_bytes.delete();
        send_message(8'h00, 8'hFF, 32'd0);
    endtask

    // also checks the return to the command phase after an empty message
    task automatic test_single_byte_body;
        body_bytes.delete();
        body_bytes.push_back(8'hA5);
        send_message(8'hFF, 8'h00, 32'd1);
    endtask

    task automatic test_empty_after_body;
        body_bytes.delete();
        send_message(8'h81, 8'h7E, 32'd0);
    endtask

    task automatic test_two_byte_body;
        body_bytes.delete();
        body_bytes.push_back(8'h00);
        body_bytes.push_back(8'hFF);
        send_message(8'h5A, 8'hC3, 32'd2);
    endtask

    task automatic test_random_messages;
        logic [LenW-1:0] len;
        int              pick;
        int              start_bytes;
        body_bytes.delete();
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) len = 0;
            else if (pick < 75) len = $urandom_range(1, 16);
            else if (pick < 95) len = $urandom_range(17, 255);
            else len = $urandom_range(256, 600);
            send_message(ByteW'($urandom), ByteW'($urandom), len);
            if ($urandom_range(0, 19) == 0) wait_drained();
        end
    endtask

    // one body long enough to need the second length byte
    task automatic test_long_body;
        body_bytes.delete();
        send_message(ByteW'($urandom), ByteW'($urandom), 32'h0000_0140);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        frame_main    = '0;
        frame_sub     = '0;
        frame_length  = '0;
        restart_command();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_message();
        test_single_byte_body();
        test_empty_after_body();
        test_two_byte_body();
        wait_drained();
        test_random_messages();
        wait_drained();
        test_long_body();

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d messages (%0d with empty body), %0d bytes in total",
                 messages_sent, empty_sent, bytes_sent);
        $display("%0d result transactions checked, %0d mismatches",
                 results_checked, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("length_prefixed_deframer_unit test passed");
        end else begin
            $display("length_prefixed_deframer_unit test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/lpd_pkg.sv
hw/rtl/lpd_in_reg.sv
hw/rtl/lpd_parser.sv
hw/rtl/length_prefixed_deframer_unit.sv
bench/tb_top.sv
